FILE: sv/atd_pkg.sv
// Shared types, constants and the arctangent table for the affine transform decomposer.
// Used by atd_unit and affine_transform_decompose. No dependencies.
package atd_pkg;

    localparam int UNIT_BITS    = 30;   // axes and angles are Q2.30 internally
    localparam int MAG_W        = 32;   // element magnitude after pre-shift
    localparam int AXIS_W       = 32;   // normalized axis component
    localparam int CROSS_W      = 34;   // cross product component
    localparam int ACC_W        = 66;   // product accumulator
    localparam int OPA_W        = 64;
    localparam int OPB_W        = 34;
    localparam int RES_W        = 68;
    localparam int CORD_W       = 35;   // CORDIC x, y and z
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [CORD_W-1:0] PI_UNIT = 35'sd3373259426;

    // input column that carries the translation and triggers a result
    localparam logic [1:0] COL_TRANS = 2'd3;

    // configuration register indexes
    localparam logic CFG_TOL = 1'b0;
    localparam logic CFG_GIM = 1'b1;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQRT,
        OP_DIV,
        OP_ATAN
    } op_t;

    // request to the shared unit
    // MUL: a[33:0] * b, signed. SQRT: a. DIV: a[31:0] << 30 / b[31:0].
    // ATAN: atan2(a[31:0], b[31:0]), signed Q2.30 operands.
    typedef struct packed {
        logic             start;
        op_t              op;
        logic [OPA_W-1:0] a;
        logic [OPB_W-1:0] b;
    } unit_req_t;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] res;
    } unit_rsp_t;

    // floor(atan(2^-i) * 2^30); past i = 9 it is 2^(30-i) - 1
    function automatic logic signed [CORD_W-1:0] atan_step(input logic [4:0] i);
        logic signed [CORD_W-1:0] t;
        begin
            t = 35'sd1 <<< (6'd30 - {1'b0, i});
            case (i)
                5'd0:    atan_step = 35'sd843314856;
                5'd1:    atan_step = 35'sd497837829;
                5'd2:    atan_step = 35'sd263043836;
                5'd3:    atan_step = 35'sd133525158;
                5'd4:    atan_step = 35'sd67021686;
                5'd5:    atan_step = 35'sd33543515;
                5'd6:    atan_step = 35'sd16775850;
                5'd7:    atan_step = 35'sd8388437;
                5'd8:    atan_step = 35'sd4194282;
                5'd9:    atan_step = 35'sd2097149;
                default: atan_step = t - 35'sd1;
            endcase
        end
    endfunction

endpackage

FILE: sv/affine_transform_decompose.sv
// Top level of the affine transform decomposer: column store, sequencer, result register.
// Depends on atd_pkg and atd_unit.
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+-----------------------------
//  cfg      | cfg_we, cfg_index, cfg_data               | register write, no wait
//  in       | in_valid/in_ready, column_index, elem_*   | one matrix column per word
//  out      | out_valid/out_ready, valid_transform, ... | one result word per column 3
//
// Columns 0..2 are stored as they are accepted. Column 3 starts the sequence that ends in its result
// word, with roll computed as well unless gimbal lock is found; a zero-length basis column
// skips its divides. Per basis column the shared unit runs three multiplies, a square root
// and three divides; then nine cross and dot multiplies, the s^2 multiply, one more square
// root and two or three CORDIC runs.
// A column 3 with |m33| under the tolerance gives its (invalid) word the next cycle.
// in_ready is low from column 3 until its result word has been taken.
// Reset sets the tolerance to 0 and the gimbal threshold to 7; the column store is not
// cleared and must be loaded before column 3.
module affine_transform_decompose #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [16:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    column_index,
    input  logic signed [WORD_WIDTH-1:0]  elem_x,
    input  logic signed [WORD_WIDTH-1:0]  elem_y,
    input  logic signed [WORD_WIDTH-1:0]  elem_z,
    input  logic signed [WORD_WIDTH-1:0]  elem_w,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          valid_transform,
    output logic signed [WORD_WIDTH-1:0]  trans_x,
    output logic signed [WORD_WIDTH-1:0]  trans_y,
    output logic signed [WORD_WIDTH-1:0]  trans_z,
    output logic signed [FRAC_BITS+2:0]   angle_pitch,
    output logic signed [FRAC_BITS+2:0]   angle_yaw,
    output logic signed [FRAC_BITS+2:0]   angle_roll,
    output logic signed [WORD_WIDTH-1:0]  scale_x,
    output logic signed [WORD_WIDTH-1:0]  scale_y,
    output logic signed [WORD_WIDTH-1:0]  scale_z
);

    localparam int W         = WORD_WIDTH;
    localparam int ANG_W     = FRAC_BITS + 3;
    localparam int PRE_SHIFT = (WORD_WIDTH > 32) ? WORD_WIDTH - 32 : 0;
    localparam int GIM_SHIFT = atd_pkg::UNIT_BITS - FRAC_BITS;
    localparam int ACC_W     = atd_pkg::ACC_W;
    localparam int AXIS_W    = atd_pkg::AXIS_W;
    localparam int CROSS_W   = atd_pkg::CROSS_W;
    localparam logic [63:0] WMAX = (64'd1 << (WORD_WIDTH - 1)) - 64'd1;
    localparam logic signed [ACC_W-1:0] ONE_SQ = 66'sd1 <<< (2 * atd_pkg::UNIT_BITS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SQ    = 10'b0000000010,   // sum of squares of one basis column
        S_ROOT  = 10'b0000000100,   // its length
        S_DIV   = 10'b0000001000,   // normalize three components
        S_CROSS = 10'b0000010000,   // axis1 x axis2
        S_DOT   = 10'b0000100000,   // triple product sign, then flip
        S_SIN   = 10'b0001000000,   // s^2
        S_COS   = 10'b0010000000,   // c = sqrt(1 - s^2)
        S_ANG   = 10'b0100000000,   // pitch, yaw, roll
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic       wait_reg, wait_next;
    logic [1:0] col_reg, col_next;
    logic [2:0] idx_reg, idx_next;

    logic [15:0] tol_reg;
    logic [16:0] gim_reg;

    logic signed [W-1:0]       basis_reg [9];
    logic signed [AXIS_W-1:0]  n_reg     [9];
    logic signed [CROSS_W-1:0] cross_reg [3];
    logic signed [W-1:0]       scale_reg [3];
    logic signed [ACC_W-1:0]   acc_reg;
    logic [31:0]               root_reg;
    logic signed [AXIS_W-1:0]  s_reg;
    logic [31:0]               c_reg;

    logic                      vt_reg;
    logic signed [W-1:0]       tx_reg, ty_reg, tz_reg;
    logic signed [ANG_W-1:0]   pitch_reg, yaw_reg, roll_reg;

    atd_pkg::unit_req_t req;
    atd_pkg::unit_rsp_t rsp;

    logic                      accept;
    logic [W-1:0]              w_abs;
    logic                      w_small;
    logic [3:0]                bidx;
    logic signed [W-1:0]       bval;
    logic [W-1:0]              babs;
    logic [atd_pkg::MAG_W-1:0] bmag;
    logic signed [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0]   diff;
    logic signed [ACC_W-1:0]   dot_sum;
    logic [63:0]               root_sh;
    logic signed [W-1:0]       scl;
    logic signed [AXIS_W-1:0]  qsgn;
    logic [39:0]               gim_sh;
    logic                      lock;
    logic                      step;
    logic                      root_zero;
    logic signed [AXIS_W-1:0]  op_a;
    logic signed [AXIS_W-1:0]  op_b;
    logic signed [CROSS_W-1:0] op_c;

    atd_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign in_ready        = state_reg == S_IDLE;
    assign out_valid       = state_reg == S_OUT;
    assign accept          = in_valid && in_ready;
    assign valid_transform = vt_reg;
    assign trans_x         = tx_reg;
    assign trans_y         = ty_reg;
    assign trans_z         = tz_reg;
    assign angle_pitch     = pitch_reg;
    assign angle_yaw       = yaw_reg;
    assign angle_roll      = roll_reg;
    assign scale_x         = scale_reg[0];
    assign scale_y         = scale_reg[1];
    assign scale_z         = scale_reg[2];

    always_comb
    begin
        w_abs   = elem_w[W-1] ? W'(-elem_w) : W'(elem_w);
        w_small = w_abs < W'(tol_reg);

        // current basis element, magnitude shifted into 32 bits
        bidx = {2'd0, col_reg} + {1'b0, col_reg, 1'b0} + {1'b0, idx_reg};
        bval = basis_reg[bidx];
        babs = bval[W-1] ? W'(-bval) : W'(bval);
        bmag = atd_pkg::MAG_W'(babs >> PRE_SHIFT);

        prod    = signed'(rsp.res[ACC_W-1:0]);
        diff    = acc_reg - prod;
        dot_sum = acc_reg + prod;

        root_sh = {32'd0, rsp.res[31:0]} << PRE_SHIFT;
        scl     = (root_sh > WMAX) ? W'(WMAX) : W'(root_sh);
        qsgn    = bval[W-1] ? -signed'({1'b0, rsp.res[30:0]}) : signed'({1'b0, rsp.res[30:0]});

        gim_sh    = 40'(gim_reg) << GIM_SHIFT;
        lock      = !({8'd0, c_reg} > gim_sh);
        root_zero = root_reg == 32'd0;
        step      = rsp.done || ((state_reg == S_DIV) && root_zero);

        // operand selection
        op_a = n_reg[0];
        op_b = n_reg[0];
        op_c = cross_reg[0];
        case (state_reg)
            S_CROSS:
            begin
                case (idx_reg)
                    3'd0:    begin op_a = n_reg[4]; op_b = n_reg[8]; end
                    3'd1:    begin op_a = n_reg[5]; op_b = n_reg[7]; end
                    3'd2:    begin op_a = n_reg[5]; op_b = n_reg[6]; end
                    3'd3:    begin op_a = n_reg[3]; op_b = n_reg[8]; end
                    3'd4:    begin op_a = n_reg[3]; op_b = n_reg[7]; end
                    default: begin op_a = n_reg[4]; op_b = n_reg[6]; end
                endcase
            end
            S_DOT:
            begin
                case (idx_reg)
                    3'd0:    begin op_a = n_reg[0]; op_c = cross_reg[0]; end
                    3'd1:    begin op_a = n_reg[1]; op_c = cross_reg[1]; end
                    default: begin op_a = n_reg[2]; op_c = cross_reg[2]; end
                endcase
            end
            S_ANG:
            begin
                case (idx_reg)
                    3'd0:    begin op_a = s_reg; op_b = signed'(c_reg); end
                    3'd1:
                    begin
                        if (lock)
                        begin
                            op_a = -n_reg[2];
                            op_b = n_reg[0];
                        end
                        else
                        begin
                            op_a = n_reg[6];
                            op_b = n_reg[8];
                        end
                    end
                    default: begin op_a = n_reg[1]; op_b = n_reg[4]; end
                endcase
            end
            default:
            begin
            end
        endcase

        req.start = 1'b0;
        req.op    = atd_pkg::OP_MUL;
        req.a     = '0;
        req.b     = '0;
        case (state_reg)
            S_SQ:
            begin
                req.op = atd_pkg::OP_MUL;
                req.a  = 64'(bmag);
                req.b  = 34'(bmag);
            end
            S_ROOT, S_COS:
            begin
                req.op = atd_pkg::OP_SQRT;
                req.a  = acc_reg[63:0];
            end
            S_DIV:
            begin
                req.op = atd_pkg::OP_DIV;
                req.a  = 64'(bmag);
                req.b  = 34'(root_reg);
            end
            S_CROSS:
            begin
                req.op = atd_pkg::OP_MUL;
                req.a  = 64'(op_a);
                req.b  = 34'(op_b);
            end
            S_DOT:
            begin
                req.op = atd_pkg::OP_MUL;
                req.a  = 64'(op_a);
                req.b  = op_c;
            end
            S_SIN:
            begin
                req.op = atd_pkg::OP_MUL;
                req.a  = 64'(s_reg);
                req.b  = 34'(s_reg);
            end
            S_ANG:
            begin
                req.op = atd_pkg::OP_ATAN;
                req.a  = 64'(op_a);
                req.b  = 34'(op_b);
            end
            default:
            begin
            end
        endcase
        req.start = !wait_reg && (state_reg != S_IDLE) && (state_reg != S_OUT)
                    && !((state_reg == S_DIV) && root_zero);

        // sequencer
        state_next = state_reg;
        col_next   = col_reg;
        idx_next   = idx_reg;
        wait_next  = wait_reg;
        if (req.start)
            wait_next = 1'b1;
        else if (rsp.done)
            wait_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (column_index == atd_pkg::COL_TRANS))
                begin
                    state_next = w_small ? S_OUT : S_SQ;
                    col_next   = 2'd0;
                    idx_next   = 3'd0;
                end
            end
            S_SQ:
            begin
                if (rsp.done)
                begin
                    if (idx_reg == 3'd2)
                    begin
                        state_next = S_ROOT;
                        idx_next   = 3'd0;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            S_ROOT:
            begin
                if (rsp.done)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step)
                begin
                    idx_next = (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                    if (idx_reg == 3'd2)
                    begin
                        if (col_reg == 2'd2)
                            state_next = S_CROSS;
                        else
                        begin
                            state_next = S_SQ;
                            col_next   = col_reg + 2'd1;
                        end
                    end
                end
            end
            S_CROSS:
            begin
                if (rsp.done)
                begin
                    idx_next = (idx_reg == 3'd5) ? 3'd0 : idx_reg + 3'd1;
                    if (idx_reg == 3'd5)
                        state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                if (rsp.done)
                begin
                    idx_next = (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                    if (idx_reg == 3'd2)
                        state_next = S_SIN;
                end
            end
            S_SIN:
            begin
                if (rsp.done)
                    state_next = S_COS;
            end
            S_COS:
            begin
                if (rsp.done)
                begin
                    state_next = S_ANG;
                    idx_next   = 3'd0;
                end
            end
            S_ANG:
            begin
                if (rsp.done)
                begin
                    // under gimbal lock roll stays zero and is not computed
                    if ((idx_reg == 3'd2) || ((idx_reg == 3'd1) && lock))
                        state_next = S_OUT;
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            col_reg   <= 2'd0;
            idx_reg   <= 3'd0;
            tol_reg   <= 16'd0;
            gim_reg   <= 17'd7;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            col_reg   <= col_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    atd_pkg::CFG_TOL: tol_reg <= cfg_data[15:0];
                    atd_pkg::CFG_GIM: gim_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (column_index == 2'(k))
                begin
                    basis_reg[3*k]     <= elem_x;
                    basis_reg[3*k + 1] <= elem_y;
                    basis_reg[3*k + 2] <= elem_z;
                end
            end
            if (column_index == atd_pkg::COL_TRANS)
            begin
                // invalid result carries zeros everywhere
                vt_reg    <= !w_small;
                tx_reg    <= w_small ? '0 : elem_x;
                ty_reg    <= w_small ? '0 : elem_y;
                tz_reg    <= w_small ? '0 : elem_z;
                pitch_reg <= '0;
                yaw_reg   <= '0;
                roll_reg  <= '0;
                for (int k = 0; k < 3; k++)
                    scale_reg[k] <= '0;
                acc_reg <= '0;
            end
        end

        case (state_reg)
            S_SQ:
            begin
                if (rsp.done)
                    acc_reg <= dot_sum;
            end
            S_ROOT:
            begin
                if (rsp.done)
                begin
                    root_reg          <= rsp.res[31:0];
                    scale_reg[col_reg] <= scl;
                end
            end
            S_DIV:
            begin
                if (step)
                begin
                    n_reg[bidx] <= root_zero ? '0 : qsgn;
                    if (idx_reg == 3'd2)
                        acc_reg <= '0;
                end
            end
            S_CROSS:
            begin
                if (rsp.done)
                begin
                    if (!idx_reg[0])
                        acc_reg <= prod;
                    else
                    begin
                        cross_reg[idx_reg[2:1]] <= CROSS_W'(diff >>> atd_pkg::UNIT_BITS);
                        acc_reg <= '0;
                    end
                end
            end
            S_DOT:
            begin
                if (rsp.done)
                begin
                    acc_reg <= dot_sum;
                    if (idx_reg == 3'd2)
                    begin
                        // left-handed basis: flip every scale and axis
                        if (dot_sum < 0)
                        begin
                            for (int k = 0; k < 3; k++)
                                scale_reg[k] <= -scale_reg[k];
                            for (int k = 0; k < 9; k++)
                                n_reg[k] <= -n_reg[k];
                        end
                        s_reg <= (dot_sum < 0) ? n_reg[7] : -n_reg[7];
                    end
                end
            end
            S_SIN:
            begin
                if (rsp.done)
                    acc_reg <= ONE_SQ - prod;
            end
            S_COS:
            begin
                if (rsp.done)
                    c_reg <= rsp.res[31:0];
            end
            S_ANG:
            begin
                if (rsp.done)
                begin
                    case (idx_reg)
                        3'd0:    pitch_reg <= rsp.res[ANG_W-1:0];
                        3'd1:    yaw_reg   <= rsp.res[ANG_W-1:0];
                        default: roll_reg  <= rsp.res[ANG_W-1:0];
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // input and output sides are never open together
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open in the same cycle");

    // the unit only reports back while the sequencer waits for it
    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> wait_reg)
        else $error("unit done without a pending request");

    // column 3 closes the input until its result is taken
    a_col3_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (column_index == atd_pkg::COL_TRANS)) |=> !in_ready)
        else $error("input still open after column 3");

    // an invalid result carries zero fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_transform) |-> (scale_x == '0) && (angle_pitch == '0)
            && (trans_x == '0) && (angle_yaw == '0))
        else $error("invalid result with nonzero fields");

endmodule

FILE: sv/atd_unit.sv
// Shared arithmetic unit: registered multiply, bit-serial square root and divide, CORDIC atan2.
// Depends on atd_pkg.
module atd_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  atd_pkg::unit_req_t req,
    output atd_pkg::unit_rsp_t rsp
);

    localparam int CW        = atd_pkg::CORD_W;
    localparam int ANG_SHIFT = atd_pkg::UNIT_BITS - FRAC_BITS;
    localparam logic signed [CW-1:0] ROUND_K = 35'sd1 <<< (ANG_SHIFT - 1);
    localparam logic signed [CW-1:0] PI_P    = atd_pkg::PI_UNIT;
    localparam logic signed [CW-1:0] PI_N    = -atd_pkg::PI_UNIT;
    localparam logic [4:0] SQRT_LAST = 5'(atd_pkg::SQRT_STEPS - 1);
    localparam logic [4:0] DIV_LAST  = 5'(atd_pkg::DIV_STEPS - 1);
    localparam logic [4:0] CORD_LAST = 5'(atd_pkg::CORDIC_STEPS - 1);

    logic              busy_reg;
    logic              done_reg;
    logic              flag_reg;
    atd_pkg::op_t      op_reg;
    logic [4:0]        cnt_reg;
    logic [63:0]       u_reg;
    logic [63:0]       v_reg;
    logic signed [CW-1:0] z_reg;
    logic signed [67:0]   p_reg;

    logic signed [67:0]   prod;
    logic [63:0]          sq_bit;
    logic [63:0]          sq_sum;
    logic                 sq_take;
    logic [31:0]          dv_d;
    logic [32:0]          dv_t;
    logic [32:0]          dv_rem;
    logic                 dv_take;
    logic signed [CW-1:0] cx, cy, dx, dy, ang, nx, ny, nz;
    logic signed [CW-1:0] ax, ay;
    logic signed [CW-1:0] zc, zr, za;
    logic                 last;

    always_comb
    begin
        prod    = 68'(signed'(req.a[33:0])) * 68'(signed'(req.b));

        // square root: one result bit per step
        sq_bit  = 64'd1 << (6'd62 - {cnt_reg, 1'b0});
        sq_sum  = v_reg + sq_bit;
        sq_take = u_reg >= sq_sum;

        // restoring divide; the only nonzero dividend bit left to shift in is a[0]
        dv_d    = p_reg[31:0];
        dv_t    = {u_reg[31:0], (cnt_reg == 5'd0) ? flag_reg : 1'b0};
        dv_take = dv_t >= {1'b0, dv_d};
        dv_rem  = dv_take ? dv_t - {1'b0, dv_d} : dv_t;

        // CORDIC vectoring
        cx  = signed'(u_reg[CW-1:0]);
        cy  = signed'(v_reg[CW-1:0]);
        dx  = cy >>> cnt_reg;
        dy  = cx >>> cnt_reg;
        ang = atd_pkg::atan_step(cnt_reg);
        if (cy > 0)
        begin
            nx = cx + dx;
            ny = cy - dy;
            nz = z_reg + ang;
        end
        else
        begin
            nx = cx - dx;
            ny = cy + dy;
            nz = z_reg - ang;
        end
        ay = CW'(signed'(req.a[31:0]));
        ax = CW'(signed'(req.b[31:0]));

        // clamp to +-pi, round half up to output precision
        if (z_reg > PI_P)
            zc = PI_P;
        else if (z_reg < PI_N)
            zc = PI_N;
        else
            zc = z_reg;
        zr = zc + ROUND_K;
        za = zr >>> ANG_SHIFT;

        case (op_reg)
            atd_pkg::OP_SQRT: last = cnt_reg == SQRT_LAST;
            atd_pkg::OP_DIV:  last = cnt_reg == DIV_LAST;
            atd_pkg::OP_ATAN: last = cnt_reg == CORD_LAST;
            default:          last = 1'b1;
        endcase

        rsp.done = done_reg;
        case (op_reg)
            atd_pkg::OP_MUL:  rsp.res = p_reg;
            atd_pkg::OP_SQRT: rsp.res = {4'd0, v_reg};
            atd_pkg::OP_DIV:  rsp.res = {4'd0, v_reg};
            atd_pkg::OP_ATAN: rsp.res = flag_reg ? '0 : 68'(za);
            default:          rsp.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= atd_pkg::OP_MUL;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg   <= req.op;
                cnt_reg  <= 5'd0;
                busy_reg <= req.op != atd_pkg::OP_MUL;
                done_reg <= req.op == atd_pkg::OP_MUL;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            case (req.op)
                atd_pkg::OP_MUL:
                begin
                    p_reg <= prod;
                end
                atd_pkg::OP_SQRT:
                begin
                    u_reg <= req.a;
                    v_reg <= 64'd0;
                end
                atd_pkg::OP_DIV:
                begin
                    u_reg    <= {33'd0, req.a[31:1]};
                    v_reg    <= 64'd0;
                    flag_reg <= req.a[0];
                    p_reg    <= {36'd0, req.b[31:0]};
                end
                atd_pkg::OP_ATAN:
                begin
                    flag_reg <= (ax == '0) && (ay == '0);
                    if (ax < 0)
                    begin
                        // rotate by pi into the right half plane
                        u_reg <= 64'(-ax);
                        v_reg <= 64'(-ay);
                        z_reg <= (ay >= 0) ? PI_P : PI_N;
                    end
                    else
                    begin
                        u_reg <= 64'(ax);
                        v_reg <= 64'(ay);
                        z_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                atd_pkg::OP_SQRT:
                begin
                    if (sq_take)
                    begin
                        u_reg <= u_reg - sq_sum;
                        v_reg <= (v_reg >> 1) + sq_bit;
                    end
                    else
                        v_reg <= v_reg >> 1;
                end
                atd_pkg::OP_DIV:
                begin
                    u_reg <= {31'd0, dv_rem};
                    v_reg <= {v_reg[62:0], dv_take};
                end
                atd_pkg::OP_ATAN:
                begin
                    u_reg <= 64'(nx);
                    v_reg <= 64'(ny);
                    z_reg <= nz;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
